FILE: design/rmx_pkg.sv
// shared types and constants for the recursive mutex with waiter queue
// no dependencies
package rmx_pkg;

   localparam int TID_W       = 8;
   localparam int NEST_W      = 8;
   localparam int MAX_THREADS = 256;
   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_NEST    = 255;
   localparam int MAP_W       = $clog2(MAX_THREADS);

   typedef enum logic [3:0] {
      ST_GRANTED    = 4'd0,
      ST_NESTED     = 4'd1,
      ST_QUEUED     = 4'd2,
      ST_UNNESTED   = 4'd3,
      ST_FREED      = 4'd4,
      ST_HANDED     = 4'd5,
      ST_NOT_HOLDER = 4'd6,
      ST_FULL       = 4'd7,
      ST_ALREADY    = 4'd8,
      ST_OVERFLOW   = 4'd9
   } status_type;

   typedef enum logic {
      REQ_ACQUIRE = 1'b0,
      REQ_RELEASE = 1'b1
   } req_kind_type;

   // control from the lock logic into the waiter fifo
   typedef struct packed {
      logic             push;
      logic             pop;
      logic [TID_W-1:0] push_tid;
   } qctl_type;

   // status from the waiter fifo back to the lock logic
   typedef struct packed {
      logic             full;
      logic             empty;
      logic [TID_W-1:0] head_tid;
   } qsts_type;

endpackage

FILE: design/recursive_mutex_with_wait_queue.sv
// top level of the recursive mutex with fifo of waiters
// depends on rmx_pkg and rmx_wait_queue
//
// one request is taken per clock whenever start is high; busy stays low, so
// requests may be issued back to back. a request is captured in the input
// register at the accepting edge and evaluated against the lock state in the
// following cycle; its response is loaded at the next edge and shown on the
// rsp_ ports with rsp_valid high for exactly one cycle. the lock state (owner,
// depth, waiter fifo) updates at the same edge that loads the response, so
// the next request sees the new state. whether a thread is already waiting
// is found by comparing its id against the occupied fifo slots, which gives
// the same answer as a per-thread waiting map cleared at reset. the
// receiver cannot stall; every response must be taken when shown.
module recursive_mutex_with_wait_queue
   import rmx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_type,
   input  logic [TID_W-1:0]  req_thread_id,
   output logic              rsp_valid,
   output logic [3:0]        rsp_status,
   output logic              rsp_woken_valid,
   output logic [TID_W-1:0]  rsp_woken_thread,
   output logic [TID_W-1:0]  rsp_owner_thread,
   output logic              rsp_owner_valid,
   output logic [NEST_W-1:0] rsp_nest_depth
);

   localparam logic [NEST_W-1:0] NEST_LIMIT = NEST_W'(MAX_NEST);

   // input register
   logic             req_valid_ff;
   req_kind_type     req_kind_ff;
   logic [TID_W-1:0] req_tid_ff;

   // lock state
   logic              held_ff, held_in;
   logic [TID_W-1:0]  owner_ff, owner_in;
   logic [NEST_W-1:0] nest_ff, nest_in;

   // result register
   logic              rsp_valid_ff;
   status_type        status_ff, status_in;
   logic              woken_valid_ff, woken_valid_in;
   logic [TID_W-1:0]  woken_tid_ff, woken_tid_in;
   logic [TID_W-1:0]  owner_out_ff;
   logic              owner_valid_ff;
   logic [NEST_W-1:0] nest_out_ff;

   qctl_type qctl;
   qsts_type qsts;
   // requester already sits in the fifo
   logic     lookup_hit;

   assign busy = 1'b0;

   rmx_wait_queue u_wait_queue (
      .clock      (clock),
      .reset      (reset),
      .qctl       (qctl),
      .qsts       (qsts),
      .lookup_tid (req_tid_ff),
      .lookup_hit (lookup_hit)
   );

   // capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_kind_ff <= req_kind_type'(req_type);
         req_tid_ff  <= req_thread_id;
      end
   end

   // single pass decision for the captured request
   always_comb begin
      held_in        = held_ff;
      owner_in       = owner_ff;
      nest_in        = nest_ff;
      status_in      = ST_GRANTED;
      woken_valid_in = 1'b0;
      woken_tid_in   = '0;
      qctl.push      = 1'b0;
      qctl.pop       = 1'b0;
      qctl.push_tid  = req_tid_ff;
      if (req_valid_ff) begin
         case (req_kind_ff)
            REQ_ACQUIRE: begin
               if (!held_ff) begin
                  // free lock: grant at depth one
                  held_in   = 1'b1;
                  owner_in  = req_tid_ff;
                  nest_in   = NEST_W'(1);
                  status_in = ST_GRANTED;
               end else if (owner_ff == req_tid_ff) begin
                  if (nest_ff >= NEST_LIMIT) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     nest_in   = nest_ff + 1'b1;
                     status_in = ST_NESTED;
                  end
               end else if (lookup_hit) begin
                  status_in = ST_ALREADY;
               end else if (qsts.full) begin
                  status_in = ST_FULL;
               end else begin
                  // contended: join the back of the fifo
                  qctl.push = 1'b1;
                  status_in = ST_QUEUED;
               end
            end
            REQ_RELEASE: begin
               if (!held_ff || (owner_ff != req_tid_ff)) begin
                  status_in = ST_NOT_HOLDER;
               end else if (nest_ff > NEST_W'(1)) begin
                  nest_in   = nest_ff - 1'b1;
                  status_in = ST_UNNESTED;
               end else if (qsts.empty) begin
                  held_in   = 1'b0;
                  owner_in  = '0;
                  nest_in   = '0;
                  status_in = ST_FREED;
               end else begin
                  // last release with waiters: hand the lock to the oldest one
                  qctl.pop       = 1'b1;
                  owner_in       = qsts.head_tid;
                  nest_in        = NEST_W'(1);
                  woken_valid_in = 1'b1;
                  woken_tid_in   = qsts.head_tid;
                  status_in      = ST_HANDED;
               end
            end
            default: begin
               status_in = ST_NOT_HOLDER;
            end
         endcase
      end
   end

   // lock state and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 1'b0;
         owner_ff     <= '0;
         nest_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         owner_ff     <= owner_in;
         nest_ff      <= nest_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         status_ff      <= status_in;
         woken_valid_ff <= woken_valid_in;
         woken_tid_ff   <= woken_tid_in;
         owner_valid_ff <= held_in;
         owner_out_ff   <= held_in ? owner_in : '0;
         nest_out_ff    <= held_in ? nest_in : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_woken_valid  = woken_valid_ff;
   assign rsp_woken_thread = woken_tid_ff;
   assign rsp_owner_thread = owner_out_ff;
   assign rsp_owner_valid  = owner_valid_ff;
   assign rsp_nest_depth   = nest_out_ff;

endmodule

FILE: design/rmx_wait_queue.sv
// fifo of waiting thread ids, head read combinationally from flops
// depends on rmx_pkg
module rmx_wait_queue
   import rmx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  qctl_type         qctl,
   output qsts_type         qsts,
   input  logic [TID_W-1:0] lookup_tid,
   output logic             lookup_hit
);

   logic [TID_W-1:0]       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      head_ff, head_in;
   logic [QPTR_W-1:0]      tail_ff, tail_in;
   logic [QFILL_W-1:0]     fill_ff, fill_in;
   // one bit per slot: set while the slot holds a waiter
   logic [QUEUE_DEPTH-1:0] occ_ff, occ_in;

   localparam logic [QPTR_W-1:0]  LAST_PTR  = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QFILL_W-1:0] FULL_FILL = QFILL_W'(QUEUE_DEPTH);

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      occ_in  = occ_ff;
      if (qctl.push) begin
         tail_in         = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
         occ_in[tail_ff] = 1'b1;
      end
      if (qctl.pop) begin
         head_in         = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
         occ_in[head_ff] = 1'b0;
      end
      if (qctl.push && !qctl.pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (qctl.pop && !qctl.push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
         occ_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         occ_ff  <= occ_in;
      end
   end

   // storage, no reset: entries are only read after being written
   always_ff @(posedge clock) begin
      if (qctl.push) begin
         slot_ff[tail_ff] <= qctl.push_tid;
      end
   end

   // is this id already waiting: compare against every occupied slot,
   // ids folded to the thread count so aliased ids match
   always_comb begin
      lookup_hit = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (occ_ff[i] && (MAP_W'(slot_ff[i]) == MAP_W'(lookup_tid))) begin
            lookup_hit = 1'b1;
         end
      end
   end

   assign qsts.full     = (fill_ff >= FULL_FILL);
   assign qsts.empty    = (fill_ff == '0);
   assign qsts.head_tid = slot_ff[head_ff];

endmodule
